FILE: design/vfs_pkg.sv
// Package for the valve flush sequencer.
// Holds the command, phase, event and register index codes, and the field widths.
// It depends on nothing else.
`timescale 1ns / 1ps

package vfs_pkg;

  // Field widths
  localparam int unsigned CmdW   = 2;
  localparam int unsigned TickW  = 16;
  localparam int unsigned DriveW = 4;
  localparam int unsigned ShownW = 3;
  localparam int unsigned EventW = 3;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 1;

  // Command codes
  localparam logic [CmdW-1:0] CmdStart = 2'd0;
  localparam logic [CmdW-1:0] CmdTick  = 2'd1;
  localparam logic [CmdW-1:0] CmdStop  = 2'd2;

  // Sequencer phases
  localparam logic [PhaseW-1:0] PhIdle  = 3'd0;
  localparam logic [PhaseW-1:0] PhPre   = 3'd1;
  localparam logic [PhaseW-1:0] PhValve = 3'd2;
  localparam logic [PhaseW-1:0] PhGap   = 3'd3;
  localparam logic [PhaseW-1:0] PhAll   = 3'd4;

  // Event codes
  localparam logic [EventW-1:0] EvNone      = 3'd0;
  localparam logic [EventW-1:0] EvStarted   = 3'd1;
  localparam logic [EventW-1:0] EvRejected  = 3'd2;
  localparam logic [EventW-1:0] EvAborted   = 3'd3;
  localparam logic [EventW-1:0] EvCompleted = 3'd4;

  // Configuration register indexes and reset values
  localparam logic [CfgIdxW-1:0] RegValveTicks = 1'd0;
  localparam logic [CfgIdxW-1:0] RegAllTicks   = 1'd1;
  localparam logic [TickW-1:0]   ValveTicksReset = 16'd50;
  localparam logic [TickW-1:0]   AllTicksReset   = 16'd100;

  // All valve drives on
  localparam logic [DriveW-1:0] DriveAll = 4'hF;

endpackage

FILE: design/valve_flush_sequencer_core.sv
`timescale 1ns / 1ps
// Valve flush sequencer core.
//
// Input channel (in_valid_i / in_ready_o) carries one beat per command: start,
// one 100 ms tick, or stop, with the system_busy flag. Output channel
// (out_valid_o / out_ready_i) returns exactly one result beat per input beat:
// pump drive, valve drive mask, shown valve, flushing flag and event code.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes valve_ticks (index 0)
// or all_ticks (index 1); it is always ready; the user must write it only while idle,
// which the block itself does not enforce.
// An input beat is held in the input register; the state update and result are then
// computed in one pass and land in the result register. Throughput is one beat per
// cycle while the receiver does not stall; all zero-length waits that expire on a
// tick resolve within that single pass.
//
// Reset puts the sequencer idle with pump and valves off and loads the default
// tick counts (50 and 100). When the receiver stalls, the result register holds
// and the input register takes one more beat before in_ready_o drops.
//
// Depends on vfs_pkg.

module valve_flush_sequencer_core #(
  parameter int unsigned VALVE_COUNT = 4,
  parameter int unsigned ROUND_COUNT = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Command channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [vfs_pkg::CmdW-1:0]       cmd_i,
  input  logic                           system_busy_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           pump_on_o,
  output logic [vfs_pkg::DriveW-1:0]     valve_mask_o,
  output logic [vfs_pkg::ShownW-1:0]     shown_valve_o,
  output logic                           flushing_o,
  output logic [vfs_pkg::EventW-1:0]     event_res_o,
  // Configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vfs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [vfs_pkg::TickW-1:0]      cfg_data_i
);

  import vfs_pkg::*;

  localparam int unsigned VW = $clog2(VALVE_COUNT + 1);
  localparam int unsigned RW = $clog2(ROUND_COUNT + 1);
  // Longest chain of expired waits in one tick: open, close, gap, all open
  localparam int unsigned ChainSteps = 4;

  // Configuration
  logic [TickW-1:0] valve_ticks_q, all_ticks_q;

  // Input register
  logic            s1_valid_q;
  logic [CmdW-1:0] s1_cmd_q;
  logic            s1_busy_q;

  // Sequencer state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [VW-1:0]     vidx_q, vidx_d;
  logic [RW-1:0]     ridx_q, ridx_d;
  logic [TickW-1:0]  wait_q, wait_d;
  logic [DriveW-1:0] drive_q, drive_d;
  logic              pump_q, pump_d;
  logic [ShownW-1:0] shown_q, shown_d;
  logic [EventW-1:0] event_d;

  // Result register
  logic              out_valid_q;
  logic              pump_out_q;
  logic [DriveW-1:0] drive_out_q;
  logic [ShownW-1:0] shown_out_q;
  logic              flush_out_q;
  logic [EventW-1:0] event_out_q;

  logic fire;

  // Move a beat into the result register when it is empty or being drained
  assign fire       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;
  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valve_ticks_q <= ValveTicksReset;
      all_ticks_q   <= AllTicksReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegValveTicks: valve_ticks_q <= cfg_data_i;
        RegAllTicks:   all_ticks_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold the accepted command beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_cmd_q  <= cmd_i;
      s1_busy_q <= system_busy_i;
    end
  end

  // Apply the command, then on a tick run every action whose wait has expired
  always_comb begin
    logic run;
    phase_d = phase_q;
    vidx_d  = vidx_q;
    ridx_d  = ridx_q;
    wait_d  = wait_q;
    drive_d = drive_q;
    pump_d  = pump_q;
    shown_d = shown_q;
    event_d = EvNone;
    run     = 1'b0;

    if (phase_q == PhIdle) begin
      if (s1_cmd_q == CmdStart) begin
        if (s1_busy_q) begin
          event_d = EvRejected;
        end else begin
          pump_d  = 1'b1;
          drive_d = DriveAll;
          shown_d = '0;
          vidx_d  = '0;
          ridx_d  = '0;
          phase_d = PhPre;
          wait_d  = TickW'(1);
          event_d = EvStarted;
        end
      end
    end else if (s1_cmd_q == CmdTick) begin
      if (wait_d != '0) wait_d = wait_d - TickW'(1);
      run = 1'b1;
    end else if (s1_cmd_q == CmdStop) begin
      phase_d = PhIdle;
      vidx_d  = '0;
      ridx_d  = '0;
      wait_d  = '0;
      drive_d = '0;
      pump_d  = 1'b0;
      shown_d = '0;
      event_d = EvAborted;
    end

    for (int k = 0; k < ChainSteps; k++) begin
      if (run && phase_d != PhIdle && wait_d == '0) begin
        case (phase_d)
          PhPre: begin
            // Open the current valve; indexes past the drive width have no bit
            drive_d = drive_d | (DriveW'(1) << vidx_d);
            shown_d = ShownW'(vidx_d) + ShownW'(1);
            phase_d = PhValve;
            wait_d  = valve_ticks_q;
          end
          PhValve: begin
            drive_d = drive_d & ~(DriveW'(1) << vidx_d);
            shown_d = '0;
            if (vidx_d == VW'(VALVE_COUNT - 1)) begin
              vidx_d = '0;
              if (ridx_d == RW'(ROUND_COUNT - 1)) begin
                ridx_d  = '0;
                phase_d = PhGap;
                wait_d  = valve_ticks_q;
              end else begin
                ridx_d  = ridx_d + RW'(1);
                phase_d = PhPre;
                wait_d  = TickW'(1);
              end
            end else begin
              vidx_d  = vidx_d + VW'(1);
              phase_d = PhPre;
              wait_d  = TickW'(1);
            end
          end
          PhGap: begin
            drive_d = DriveAll;
            shown_d = '0;
            phase_d = PhAll;
            wait_d  = all_ticks_q;
          end
          default: begin
            // All-open time is over: switch everything off
            phase_d = PhIdle;
            vidx_d  = '0;
            ridx_d  = '0;
            wait_d  = '0;
            drive_d = '0;
            pump_d  = 1'b0;
            shown_d = '0;
            event_d = EvCompleted;
          end
        endcase
      end
    end
  end

  // Advance sequencer state once per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      vidx_q  <= '0;
      ridx_q  <= '0;
      wait_q  <= '0;
      drive_q <= '0;
      pump_q  <= 1'b0;
      shown_q <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      vidx_q  <= vidx_d;
      ridx_q  <= ridx_d;
      wait_q  <= wait_d;
      drive_q <= drive_d;
      pump_q  <= pump_d;
      shown_q <= shown_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      pump_out_q  <= pump_d;
      drive_out_q <= drive_d;
      shown_out_q <= shown_d;
      flush_out_q <= (phase_d != PhIdle);
      event_out_q <= event_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pump_on_o     = pump_out_q;
  assign valve_mask_o  = drive_out_q;
  assign shown_valve_o = shown_out_q;
  assign flushing_o    = flush_out_q;
  assign event_res_o   = event_out_q;

endmodule
